FILE: rtl/tgbc_pkg.sv
package tgbc_pkg;

	// field widths
	localparam int BPM_W      = 10;
	localparam int PEAK_W     = 16;
	localparam int STEP_W     = 20;
	localparam int TEMPO_W    = 13;
	localparam int WIN_W      = 24;
	localparam int CNT_W      = 32;
	localparam int BEATS_W    = 8;
	localparam int QUO_W      = 15;
	localparam int MIN_US_W   = 25;
	localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// arithmetic constants
	localparam logic [QUO_W-1:0]    HALF_MINUTE_MS = QUO_W'(30000);
	localparam logic [BPM_W-1:0]    MS_TO_US       = BPM_W'(1000);
	localparam logic [4:0]          TEMPO_SCALE    = 5'd30;
	localparam logic [BEATS_W-1:0]  BEAT_MAX       = 8'd255;
	localparam logic [MIN_US_W-1:0] MIN_US_MAX     = MIN_US_W'(30000000);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;

	localparam logic [PEAK_W-1:0] PEAK_THRESHOLD_RST = PEAK_W'(29492);
	localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST  = WIN_W'(2000000);

endpackage

FILE: rtl/tgbc_div.sv
// Restoring divider: HALF_MINUTE_MS / divisor, one quotient bit per cycle.
module tgbc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tgbc_pkg::BPM_W-1:0]   divisor,
	output logic                         done,
	output logic [tgbc_pkg::QUO_W-1:0]   quotient
);

	logic [tgbc_pkg::BPM_W-1:0]     div_q;
	logic [tgbc_pkg::BPM_W-1:0]     rem_q;
	logic [tgbc_pkg::QUO_W-1:0]     quo_q;
	logic [tgbc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [tgbc_pkg::BPM_W:0] trial;
	logic [tgbc_pkg::BPM_W:0] diff;
	logic                     fits;

	assign trial = {rem_q, quo_q[tgbc_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the last quotient bit
			done_q <= busy_q && !start && (cnt_q == tgbc_pkg::DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tgbc_pkg::DIV_CNT_W'(tgbc_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tgbc_pkg::DIV_CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= tgbc_pkg::HALF_MINUTE_MS;
		end else if (busy_q) begin
			rem_q <= fits ? diff[tgbc_pkg::BPM_W-1:0] : trial[tgbc_pkg::BPM_W-1:0];
			quo_q <= {quo_q[tgbc_pkg::QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/tempo_gated_beat_counter.sv
// Tempo-gated beat counter. One result transfer per input transfer, in order.
// A frame that finds the gate idle arms it: a minimum beat interval of
// floor(30000 / bpm) ms (0 bpm counts as 1) is worked out by a
// restoring divider, one quotient bit a cycle, and that frame never beats.
// An armed frame beats when more than the interval has elapsed and the peak is
// at or above peak_threshold. Both microsecond counters then advance by step_us
// (saturating at 2^32-1); once the window counter exceeds window_length_us the
// tempo (beats times 30) is published, and count, window and gate are cleared.
// An arming frame passes ST_DIV, where the divider finds the 15 quotient bits,
// then ST_ADD, ST_WIN and ST_OUT; an armed frame passes ST_TEST, ST_ADD, ST_WIN
// and ST_OUT. The divider sets the worst case. in_stall is high from the input
// transfer until the result has been loaded into the output register; a
// result waiting on out_stall holds the next frame back only once its own
// result is ready. Configuration writes are always accepted (cfg_ready tied
// high); write only while no frame is in flight. No clearing pass after reset.
module tempo_gated_beat_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgbc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// frame input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tgbc_pkg::BPM_W-1:0]          tempo_hint_bpm,
	input  logic [tgbc_pkg::PEAK_W-1:0]         peak_level,
	input  logic [tgbc_pkg::STEP_W-1:0]         step_us,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                beat,
	output logic [tgbc_pkg::TEMPO_W-1:0]        tempo_bpm
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TEST,
		ST_ADD,
		ST_WIN,
		ST_OUT
	} state_t;

	state_t state_q;

	// config registers
	logic [tgbc_pkg::PEAK_W-1:0] thr_q;
	logic [tgbc_pkg::WIN_W-1:0]  win_len_q;

	// block state
	logic                           armed_q;
	logic [tgbc_pkg::MIN_US_W-1:0]  min_us_q;   // min interval, held in us
	logic [tgbc_pkg::CNT_W-1:0]     interval_q;
	logic [tgbc_pkg::CNT_W-1:0]     window_q;
	logic [tgbc_pkg::BEATS_W-1:0]   beats_q;
	logic [tgbc_pkg::TEMPO_W-1:0]   published_q;

	// frame in flight
	logic [tgbc_pkg::PEAK_W-1:0]    peak_q;
	logic [tgbc_pkg::STEP_W-1:0]    step_q;
	logic                           beat_q;

	// output register
	logic                           out_valid_q;
	logic                           out_beat_q;
	logic [tgbc_pkg::TEMPO_W-1:0]   out_tempo_q;

	logic                           in_acc;
	logic                           div_start;
	logic                           div_done;
	logic [tgbc_pkg::BPM_W-1:0]     divisor;
	logic [tgbc_pkg::QUO_W-1:0]     quotient;
	logic [tgbc_pkg::MIN_US_W-1:0]  min_us_next;
	logic [tgbc_pkg::CNT_W:0]       interval_sum;
	logic [tgbc_pkg::CNT_W:0]       window_sum;
	logic [tgbc_pkg::TEMPO_W-1:0]   tempo_next;
	logic                           out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// zero tempo counts as 1 bpm
	assign divisor   = (tempo_hint_bpm == '0) ? tgbc_pkg::BPM_W'(1) : tempo_hint_bpm;
	assign div_start = in_acc && !armed_q;

	tgbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign min_us_next  = tgbc_pkg::MIN_US_W'(quotient) *
	                      tgbc_pkg::MIN_US_W'(tgbc_pkg::MS_TO_US);
	assign interval_sum = {1'b0, interval_q} + (tgbc_pkg::CNT_W + 1)'(step_q);
	assign window_sum   = {1'b0, window_q} + (tgbc_pkg::CNT_W + 1)'(step_q);
	assign tempo_next   = tgbc_pkg::TEMPO_W'(beats_q) *
	                      tgbc_pkg::TEMPO_W'(tgbc_pkg::TEMPO_SCALE);
	assign out_free     = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= tgbc_pkg::PEAK_THRESHOLD_RST;
			win_len_q   <= tgbc_pkg::WINDOW_LENGTH_RST;
			armed_q     <= 1'b0;
			min_us_q    <= '0;
			interval_q  <= '0;
			window_q    <= '0;
			beats_q     <= '0;
			published_q <= '0;
			beat_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tgbc_pkg::REG_PEAK_THRESHOLD: thr_q <= cfg_data[tgbc_pkg::PEAK_W-1:0];
					tgbc_pkg::REG_WINDOW_LENGTH:  win_len_q <= cfg_data;
					default: ;
				endcase
			end

			// load a new result, or drop the one just transferred
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						beat_q  <= 1'b0;
						state_q <= armed_q ? ST_TEST : ST_DIV;
					end
				end
				ST_DIV: begin
					// arm: interval restarts, frame gives no beat
					if (div_done) begin
						min_us_q   <= min_us_next;
						armed_q    <= 1'b1;
						interval_q <= '0;
						state_q    <= ST_ADD;
					end
				end
				ST_TEST: begin
					if (interval_q > tgbc_pkg::CNT_W'(min_us_q) && peak_q >= thr_q) begin
						if (beats_q != tgbc_pkg::BEAT_MAX)
							beats_q <= beats_q + 1'b1;
						beat_q     <= 1'b1;
						armed_q    <= 1'b0;
						interval_q <= '0;
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					interval_q <= interval_sum[tgbc_pkg::CNT_W] ? '1
					                                              : interval_sum[tgbc_pkg::CNT_W-1:0];
					window_q   <= window_sum[tgbc_pkg::CNT_W] ? '1
					                                            : window_sum[tgbc_pkg::CNT_W-1:0];
					state_q    <= ST_WIN;
				end
				ST_WIN: begin
					// end of window: publish and start over, excess dropped
					if (window_q > tgbc_pkg::CNT_W'(win_len_q)) begin
						published_q <= tempo_next;
						beats_q     <= '0;
						window_q    <= '0;
						armed_q     <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// frame and result payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			peak_q <= peak_level;
			step_q <= step_us;
		end
		if (state_q == ST_OUT && out_free) begin
			out_beat_q  <= beat_q;
			out_tempo_q <= published_q;
		end
	end

	assign out_valid = out_valid_q;
	assign beat      = out_beat_q;
	assign tempo_bpm = out_tempo_q;

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_arm_goes_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !armed_q |=> state_q == ST_DIV)
		else $error("arming frame did not start the divider");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result loaded outside the output state");

	a_min_interval_range: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> min_us_q <= tgbc_pkg::MIN_US_MAX)
		else $error("minimum interval out of range");
`endif

endmodule
